@@ design/tx_packet_admit_and_stamp_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the transmit packet admit and stamp block
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef TX_PACKET_ADMIT_AND_STAMP_MACROS_SVH
`define TX_PACKET_ADMIT_AND_STAMP_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define TPAS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpas: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define TPAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpas: next-cycle check failed");

`endif

@@ design/tpas_pkg.sv @@
// ---------------------------------------------------------------------------
// tpas_pkg
// Types and constants shared by the transmit packet admit and stamp block.
// ---------------------------------------------------------------------------
package tpas_pkg;

  // Feed grid and packet size, in samples.
  localparam int unsigned GRID_SAMPLES   = 256;
  localparam int unsigned GRID_BITS      = $clog2(GRID_SAMPLES);
  localparam int unsigned PACKET_SAMPLES = 4096;
  localparam int unsigned SAMPLES_W      = $clog2(PACKET_SAMPLES + 1);

  // Register reset values.
  localparam logic [30:0] CC_WINDOW_RESET   = 31'd2000;
  localparam logic [15:0] QUEUE_LIMIT_RESET = 16'd256;

  // Item actions; the fourth code is unused and refused.
  typedef enum logic [1:0] {
    ACT_PACKET   = 2'd0,
    ACT_SEEK_REL = 2'd1,
    ACT_SEEK_ABS = 2'd2
  } tpas_action_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_UNSUPPORTED  = 3'd1,
    ST_FULL         = 3'd2,
    ST_NOT_ANCHORED = 3'd3,
    ST_BACKWARDS    = 3'd4
  } tpas_status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CC_WINDOW   = 2'd0,
    REG_QUEUE_LIMIT = 2'd1,
    REG_MIN_LEAD    = 2'd2,
    REG_LEAD        = 2'd3
  } tpas_reg_e;

  // Configuration register contents.
  typedef struct packed {
    logic [30:0] cc_window;
    logic [15:0] queue_limit;
    logic [31:0] min_lead_ticks;
    logic [31:0] lead_ticks;
  } tpas_cfg_t;

  // One input item.
  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] count;
    logic        caller_stamped;
    logic        end_of_burst;
    logic [63:0] device_consumed_cc;
    logic [15:0] queue_level;
    logic [31:0] device_t0;
    logic [7:0]  device_epoch;
    logic [4:0]  device_r_shift;
    logic [31:0] device_now;
  } tpas_item_t;

  // One result item.
  typedef struct packed {
    tpas_status_e status;
    logic         admitted;
    logic [31:0]  sequence_count;
    logic         stamp_valid;
    logic [31:0]  stamp_tick;
    logic [7:0]   stamp_epoch;
    logic         stamp_end_of_burst;
    logic [63:0]  feed_position;
  } tpas_result_t;

endpackage

@@ design/tpas_if.sv @@
// ---------------------------------------------------------------------------
// tpas_if
// Valid/ready channel interfaces for items, results and register writes.
// ---------------------------------------------------------------------------

// Input item channel.
interface tpas_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] count;
  logic        caller_stamped;
  logic        end_of_burst;
  logic [63:0] device_consumed_cc;
  logic [15:0] queue_level;
  logic [31:0] device_t0;
  logic [7:0]  device_epoch;
  logic [4:0]  device_r_shift;
  logic [31:0] device_now;

  modport source (
    output valid, action, count, caller_stamped, end_of_burst, device_consumed_cc,
           queue_level, device_t0, device_epoch, device_r_shift, device_now,
    input  ready
  );
  modport sink (
    input  valid, action, count, caller_stamped, end_of_burst, device_consumed_cc,
           queue_level, device_t0, device_epoch, device_r_shift, device_now,
    output ready
  );
endinterface

// Result channel.
interface tpas_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        admitted;
  logic [31:0] sequence_count;
  logic        stamp_valid;
  logic [31:0] stamp_tick;
  logic [7:0]  stamp_epoch;
  logic        stamp_end_of_burst;
  logic [63:0] feed_position;

  modport source (
    output valid, status, admitted, sequence_count, stamp_valid, stamp_tick,
           stamp_epoch, stamp_end_of_burst, feed_position,
    input  ready
  );
  modport sink (
    input  valid, status, admitted, sequence_count, stamp_valid, stamp_tick,
           stamp_epoch, stamp_end_of_burst, feed_position,
    output ready
  );
endinterface

// Register write channel.
interface tpas_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/tx_packet_admit_and_stamp.sv @@
// ---------------------------------------------------------------------------
// tx_packet_admit_and_stamp: transmit packet admission, feed seek and stamp
// An item passes two registers on its way to the result: input register, result register.
// Throughput is one item per cycle while the result channel takes results; a held result stalls the input.
// Asynchronous active-low reset clears feed state, anchor and channel valids.
// ---------------------------------------------------------------------------
module tx_packet_admit_and_stamp (
  input  logic           clk_i,
  input  logic           rst_ni,
  tpas_item_if.sink      item_i,
  tpas_result_if.source  result_o,
  tpas_cfg_if.sink       cfg_i
);

  tpas_pkg::tpas_cfg_t    cfg;
  tpas_pkg::tpas_item_t   item_q, item_d;
  tpas_pkg::tpas_result_t res_q, res_d;
  logic                   item_valid_q, item_valid_d;
  logic                   res_valid_q, res_valid_d;
  logic                   out_free;
  logic                   fire;
  logic                   in_xfer;

  // Configuration registers.
  tpas_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Handshake: the input register drains into the result register when it is free.
  assign out_free     = !res_valid_q || result_o.ready;
  assign fire         = item_valid_q && out_free;
  assign item_i.ready = !item_valid_q || out_free;
  assign in_xfer      = item_i.valid && item_i.ready;

  // Input register load.
  always_comb begin
    item_d                    = item_q;
    item_d.action             = item_i.action;
    item_d.count              = item_i.count;
    item_d.caller_stamped     = item_i.caller_stamped;
    item_d.end_of_burst       = item_i.end_of_burst;
    item_d.device_consumed_cc = item_i.device_consumed_cc;
    item_d.queue_level        = item_i.queue_level;
    item_d.device_t0          = item_i.device_t0;
    item_d.device_epoch       = item_i.device_epoch;
    item_d.device_r_shift     = item_i.device_r_shift;
    item_d.device_now         = item_i.device_now;
    item_valid_d              = in_xfer ? 1'b1 : (fire ? 1'b0 : item_valid_q);
    res_valid_d               = fire ? 1'b1 : (result_o.ready ? 1'b0 : res_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= item_d;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  // Admit, seek and stamp logic with the feed state.
  tpas_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (item_q),
    .fire_i   (fire),
    .result_o (res_d)
  );

  // Result channel.
  assign result_o.valid              = res_valid_q;
  assign result_o.status             = res_q.status;
  assign result_o.admitted           = res_q.admitted;
  assign result_o.sequence_count     = res_q.sequence_count;
  assign result_o.stamp_valid        = res_q.stamp_valid;
  assign result_o.stamp_tick         = res_q.stamp_tick;
  assign result_o.stamp_epoch        = res_q.stamp_epoch;
  assign result_o.stamp_end_of_burst = res_q.stamp_end_of_burst;
  assign result_o.feed_position      = res_q.feed_position;

endmodule

@@ design/tpas_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// tpas_cfg_regs
// Configuration registers, written through the register write channel.
// ---------------------------------------------------------------------------
module tpas_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tpas_cfg_if.sink             cfg_i,
  output tpas_pkg::tpas_cfg_t  cfg_o
);

  tpas_pkg::tpas_cfg_t cfg_q, cfg_d;

  // Writes are taken in every cycle.
  assign cfg_i.ready = 1'b1;

  // Decode one register write per transfer.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        tpas_pkg::REG_CC_WINDOW:   cfg_d.cc_window      = cfg_i.data[30:0];
        tpas_pkg::REG_QUEUE_LIMIT: cfg_d.queue_limit    = cfg_i.data[15:0];
        tpas_pkg::REG_MIN_LEAD:    cfg_d.min_lead_ticks = cfg_i.data;
        tpas_pkg::REG_LEAD:        cfg_d.lead_ticks     = cfg_i.data;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cc_window      <= tpas_pkg::CC_WINDOW_RESET;
      cfg_q.queue_limit    <= tpas_pkg::QUEUE_LIMIT_RESET;
      cfg_q.min_lead_ticks <= 32'd0;
      cfg_q.lead_ticks     <= 32'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/tpas_core.sv @@
// ---------------------------------------------------------------------------
// tpas_core
// Feed state and the admit, seek and stamp logic for one registered item.
// ---------------------------------------------------------------------------
`include "tx_packet_admit_and_stamp_macros.svh"

module tpas_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tpas_pkg::tpas_cfg_t     cfg_i,
  input  tpas_pkg::tpas_item_t    item_i,
  input  logic                    fire_i,
  output tpas_pkg::tpas_result_t  result_o
);

  // Auto-seek sample value: doubled tick offset shifted down by the ratio.
  localparam int unsigned AheadW = 33;
  localparam int unsigned IdxW   = AheadW - tpas_pkg::GRID_BITS + 1;
  localparam int unsigned PadW   = 64 - IdxW - tpas_pkg::GRID_BITS;
  localparam int unsigned SampW  = tpas_pkg::SAMPLES_W;

  logic [63:0] issued_cc_q, issued_cc_d;
  logic [63:0] play_pos_q, play_pos_d;
  logic        seek_declared_q, seek_declared_d;
  logic        anchor_valid_q, anchor_valid_d;
  logic [31:0] anchor_t0_q, anchor_t0_d;
  logic [7:0]  anchor_epoch_q, anchor_epoch_d;
  logic [4:0]  anchor_shift_q, anchor_shift_d;

  tpas_pkg::tpas_result_t res;

  logic [63:0]        gap;
  logic               window_over;
  logic               pkt_count_bad;
  logic               epoch_present;
  logic [SampW-1:0]   samples;
  logic [31:0]        lead_sel;
  logic [31:0]        ahead;
  logic [AheadW-1:0]  ahead_smp;
  logic [IdxW-1:0]    grid_next;
  logic [63:0]        auto_pos;
  logic [31:0]        t0_eff;
  logic [4:0]         shift_eff;
  logic [63:0]        stamp_pos;
  logic [31:0]        pos_ticks;

  // Admission checks and auto-seek arithmetic.
  always_comb begin
    gap           = issued_cc_q - item_i.device_consumed_cc;
    window_over   = !gap[63] && (gap > {33'd0, cfg_i.cc_window});
    pkt_count_bad = (item_i.count != 64'd0) &&
                    ((item_i.count[tpas_pkg::GRID_BITS-1:0] != '0) ||
                     (item_i.count > 64'(tpas_pkg::PACKET_SAMPLES)));
    epoch_present = item_i.device_epoch != 8'd0;
    samples       = (item_i.count == 64'd0) ? SampW'(tpas_pkg::PACKET_SAMPLES)
                                            : item_i.count[SampW-1:0];
    lead_sel      = (cfg_i.min_lead_ticks != 32'd0) ? cfg_i.min_lead_ticks
                                                    : cfg_i.lead_ticks;
    ahead         = item_i.device_now + {lead_sel[30:0], 1'b0} - item_i.device_t0;
    ahead_smp     = {ahead, 1'b0} >> item_i.device_r_shift;
    grid_next     = IdxW'(ahead_smp[AheadW-1:tpas_pkg::GRID_BITS]) + IdxW'(1);
    auto_pos      = {{PadW{1'b0}}, grid_next, {tpas_pkg::GRID_BITS{1'b0}}};
  end

  // Item processing and next state.
  always_comb begin
    issued_cc_d     = issued_cc_q;
    play_pos_d      = play_pos_q;
    seek_declared_d = seek_declared_q;
    anchor_valid_d  = anchor_valid_q;
    anchor_t0_d     = anchor_t0_q;
    anchor_epoch_d  = anchor_epoch_q;
    anchor_shift_d  = anchor_shift_q;
    t0_eff          = anchor_t0_q;
    shift_eff       = anchor_shift_q;
    stamp_pos       = play_pos_q;
    pos_ticks       = 32'd0;
    res             = '0;
    res.status      = tpas_pkg::ST_OK;

    case (item_i.action)
      tpas_pkg::ACT_SEEK_REL, tpas_pkg::ACT_SEEK_ABS: begin
        seek_declared_d = 1'b1;
        if (item_i.count[tpas_pkg::GRID_BITS-1:0] != '0) begin
          res.status = tpas_pkg::ST_UNSUPPORTED;
        end else if (item_i.action == tpas_pkg::ACT_SEEK_REL) begin
          play_pos_d = play_pos_q + item_i.count;
        end else if (item_i.count < play_pos_q) begin
          res.status = tpas_pkg::ST_BACKWARDS;
        end else begin
          play_pos_d = item_i.count;
          if (epoch_present) begin
            anchor_valid_d = 1'b1;
            anchor_t0_d    = item_i.device_t0;
            anchor_epoch_d = item_i.device_epoch;
            anchor_shift_d = item_i.device_r_shift;
          end
        end
      end
      tpas_pkg::ACT_PACKET: begin
        if (pkt_count_bad) begin
          res.status = tpas_pkg::ST_UNSUPPORTED;
        end else if (window_over || (item_i.queue_level >= cfg_i.queue_limit)) begin
          res.status = tpas_pkg::ST_FULL;
        end else if (!item_i.caller_stamped && seek_declared_q && !anchor_valid_q &&
                     !epoch_present) begin
          res.status = tpas_pkg::ST_NOT_ANCHORED;
        end else begin
          issued_cc_d        = issued_cc_q + 64'd1;
          res.admitted       = 1'b1;
          res.sequence_count = issued_cc_d[31:0];
          if (!item_i.caller_stamped && (anchor_valid_q || epoch_present)) begin
            // First stamp latches the anchor and may start the feed ahead of now.
            if (!anchor_valid_q) begin
              anchor_valid_d = 1'b1;
              anchor_t0_d    = item_i.device_t0;
              anchor_epoch_d = item_i.device_epoch;
              anchor_shift_d = item_i.device_r_shift;
              t0_eff         = item_i.device_t0;
              shift_eff      = item_i.device_r_shift;
              if (!seek_declared_q && (play_pos_q == 64'd0)) begin
                stamp_pos = auto_pos;
              end
            end
            // Ticks per sample are 2^shift/2.
            if (shift_eff == 5'd0) begin
              pos_ticks = stamp_pos[32:1];
            end else begin
              pos_ticks = stamp_pos[31:0] << (shift_eff - 5'd1);
            end
            res.stamp_valid        = 1'b1;
            res.stamp_tick         = t0_eff + pos_ticks;
            res.stamp_epoch        = anchor_epoch_d;
            res.stamp_end_of_burst = item_i.end_of_burst;
            play_pos_d             = stamp_pos + {{(64-SampW){1'b0}}, samples};
          end
        end
      end
      default: begin
        res.status = tpas_pkg::ST_UNSUPPORTED;
      end
    endcase

    res.feed_position = play_pos_d;
  end

  // State advances only on an item that moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issued_cc_q     <= 64'd0;
      play_pos_q      <= 64'd0;
      seek_declared_q <= 1'b0;
      anchor_valid_q  <= 1'b0;
      anchor_t0_q     <= 32'd0;
      anchor_epoch_q  <= 8'd0;
      anchor_shift_q  <= 5'd0;
    end else if (fire_i) begin
      issued_cc_q     <= issued_cc_d;
      play_pos_q      <= play_pos_d;
      seek_declared_q <= seek_declared_d;
      anchor_valid_q  <= anchor_valid_d;
      anchor_t0_q     <= anchor_t0_d;
      anchor_epoch_q  <= anchor_epoch_d;
      anchor_shift_q  <= anchor_shift_d;
    end
  end

  assign result_o = res;

  // Consistency checks.
  `TPAS_ASSERT_IMPL(a_admit_ok, clk_i, rst_ni, fire_i && res.admitted, res.status == tpas_pkg::ST_OK)
  `TPAS_ASSERT_IMPL(a_stamp_admit, clk_i, rst_ni, fire_i && res.stamp_valid, res.admitted)
  `TPAS_ASSERT_NEXT(a_refused_cc, clk_i, rst_ni, fire_i && !res.admitted, $stable(issued_cc_q))
  `TPAS_ASSERT_NEXT(a_seq_next, clk_i, rst_ni, fire_i && res.admitted, issued_cc_q[31:0] == $past(res.sequence_count))
  `TPAS_ASSERT_NEXT(a_anchor_sticky, clk_i, rst_ni, anchor_valid_q, anchor_valid_q)

endmodule

@@ tb/tpas_admit_monitor.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpas_admit_monitor
// Watches the item, result and register write channels of the transmit
// packet admit and stamp block. It keeps its own copy of the admission,
// feed position and anchor state, works out the result of every accepted
// item and compares each result transfer, field by field, with the oldest
// outstanding prediction.
// ---------------------------------------------------------------------------
module tpas_admit_monitor
  import tpas_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  tpas_item_if          item_mon,
  tpas_result_if        result_mon,
  tpas_cfg_if           cfg_mon,
  output int            fail_count_o,
  output int            pending_o
);

  // Register copies.
  logic [30:0] cc_window;
  logic [15:0] queue_limit;
  logic [31:0] min_lead;
  logic [31:0] lead_ticks;

  // Admission, feed and anchor state.
  logic [63:0] issued_cc;
  logic [63:0] play_pos;
  logic        seek_declared;
  logic        anchor_valid;
  logic [31:0] anchor_t0;
  logic [7:0]  anchor_epoch;
  logic [4:0]  anchor_shift;

  // Predicted results not yet seen on the result channel.
  tpas_result_t results_due[$];
  int           mismatch_count;
  int           results_seen;

  assign fail_count_o = mismatch_count;
  assign pending_o    = results_due.size();

  function automatic void latch_anchor(input tpas_item_t it);
    anchor_t0    = it.device_t0;
    anchor_epoch = it.device_epoch;
    anchor_shift = it.device_r_shift;
    anchor_valid = 1'b1;
  endfunction

  // Ticks per sample are 2^shift / 2, so shift zero halves the position.
  function automatic logic [31:0] scale_to_ticks(input logic [63:0] pos,
                                                 input logic [4:0] shift);
    logic [63:0] scaled;
    if (shift == '0) begin
      scaled = pos >> 1;
    end else begin
      scaled = pos << (shift - 1);
    end
    return scaled[31:0];
  endfunction

  // Applies one item to the state and returns the result it produces.
  function automatic tpas_result_t admit_and_stamp(input tpas_item_t it);
    tpas_result_t r;
    logic [63:0]  gap;
    logic [31:0]  lead;
    logic [31:0]  ahead;
    logic [63:0]  grid_pos;
    logic [63:0]  samples;
    r = '0;
    r.status = ST_OK;
    case (it.action)
      ACT_SEEK_REL, ACT_SEEK_ABS: begin
        // A seek is declared even when it is refused.
        seek_declared = 1'b1;
        if (it.count[GRID_BITS-1:0] != '0) begin
          r.status = ST_UNSUPPORTED;
        end else if (it.action == ACT_SEEK_REL) begin
          play_pos = play_pos + it.count;
        end else if (it.count < play_pos) begin
          r.status = ST_BACKWARDS;
        end else begin
          play_pos = it.count;
          if (it.device_epoch != '0) begin
            latch_anchor(it);
          end
        end
      end
      ACT_PACKET: begin
        gap = issued_cc - it.device_consumed_cc;
        if (it.count != '0 &&
            (it.count[GRID_BITS-1:0] != '0 || it.count > PACKET_SAMPLES)) begin
          r.status = ST_UNSUPPORTED;
        end else if (!gap[63] && gap > {33'b0, cc_window}) begin
          // A negative gap means the device is ahead: the window is open.
          r.status = ST_FULL;
        end else if (it.queue_level >= queue_limit) begin
          r.status = ST_FULL;
        end else if (!it.caller_stamped && seek_declared && !anchor_valid &&
                     it.device_epoch == '0) begin
          r.status = ST_NOT_ANCHORED;
        end else begin
          issued_cc = issued_cc + 64'd1;
          r.admitted = 1'b1;
          r.sequence_count = issued_cc[31:0];
          if (!it.caller_stamped && (anchor_valid || it.device_epoch != '0)) begin
            samples = (it.count != '0) ? it.count : 64'(PACKET_SAMPLES);
            if (!anchor_valid) begin
              latch_anchor(it);
              // First unsought packet starts twice the lead ahead of now.
              if (!seek_declared && play_pos == '0) begin
                lead = (min_lead != '0) ? min_lead : lead_ticks;
                ahead = it.device_now + (lead << 1) - anchor_t0;
                grid_pos = ({32'b0, ahead} << 1) >> anchor_shift;
                play_pos = ((grid_pos >> GRID_BITS) + 64'd1) << GRID_BITS;
              end
            end
            r.stamp_valid = 1'b1;
            r.stamp_tick = anchor_t0 + scale_to_ticks(play_pos, anchor_shift);
            r.stamp_epoch = anchor_epoch;
            r.stamp_end_of_burst = it.end_of_burst;
            play_pos = play_pos + samples;
          end
        end
      end
      default: begin
        r.status = ST_UNSUPPORTED;
      end
    endcase
    r.feed_position = play_pos;
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      if (mismatch_count < 10) begin
        $display("%0t: result %0d %s mismatch: expected 0x%0h, actual 0x%0h",
                 $time, results_seen, what, want, got);
      end
      mismatch_count++;
    end
  endfunction

  // Result checks come first: a result never leaves in the cycle its item
  // is taken, so this keeps a stray result from matching a fresh prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    tpas_item_t   it;
    tpas_result_t want;
    if (!rst_ni) begin
      cc_window      = CC_WINDOW_RESET;
      queue_limit    = QUEUE_LIMIT_RESET;
      min_lead       = '0;
      lead_ticks     = '0;
      issued_cc      = '0;
      play_pos       = '0;
      seek_declared  = 1'b0;
      anchor_valid   = 1'b0;
      anchor_t0      = '0;
      anchor_epoch   = '0;
      anchor_shift   = '0;
      mismatch_count = 0;
      results_seen   = 0;
      results_due.delete();
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (results_due.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: result transfer with no prediction outstanding", $time);
          end
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          check_field("status", 64'(want.status), 64'(result_mon.status));
          check_field("admitted", 64'(want.admitted), 64'(result_mon.admitted));
          check_field("sequence_count", 64'(want.sequence_count),
                      64'(result_mon.sequence_count));
          check_field("stamp_valid", 64'(want.stamp_valid), 64'(result_mon.stamp_valid));
          check_field("stamp_tick", 64'(want.stamp_tick), 64'(result_mon.stamp_tick));
          check_field("stamp_epoch", 64'(want.stamp_epoch), 64'(result_mon.stamp_epoch));
          check_field("stamp_end_of_burst", 64'(want.stamp_end_of_burst),
                      64'(result_mon.stamp_end_of_burst));
          check_field("feed_position", want.feed_position, result_mon.feed_position);
        end
        results_seen++;
      end

      // Register writes only happen while the block is idle.
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_CC_WINDOW:   cc_window   = cfg_mon.data[30:0];
          REG_QUEUE_LIMIT: queue_limit = cfg_mon.data[15:0];
          REG_MIN_LEAD:    min_lead    = cfg_mon.data;
          REG_LEAD:        lead_ticks  = cfg_mon.data;
          default: ;
        endcase
      end

      if (item_mon.valid && item_mon.ready) begin
        it.action             = item_mon.action;
        it.count              = item_mon.count;
        it.caller_stamped     = item_mon.caller_stamped;
        it.end_of_burst       = item_mon.end_of_burst;
        it.device_consumed_cc = item_mon.device_consumed_cc;
        it.queue_level        = item_mon.queue_level;
        it.device_t0          = item_mon.device_t0;
        it.device_epoch       = item_mon.device_epoch;
        it.device_r_shift     = item_mon.device_r_shift;
        it.device_now         = item_mon.device_now;
        results_due.push_back(admit_and_stamp(it));
      end
    end
  end

endmodule

@@ tb/tx_packet_admit_and_stamp_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tx_packet_admit_and_stamp_tb
// Drives packet writes and feed seeks into the admit and stamp block: a
// short directed run over refusals, the first-packet auto seek, anchor
// latching and position wrap, then random traffic under several register
// settings and idle patterns. The monitor checks every result transfer.
// ---------------------------------------------------------------------------
module tx_packet_admit_and_stamp_tb;
  import tpas_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  // The fourth action code has no enum member; the block must refuse it.
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;

  logic clk;
  logic rst_n;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          fail_count;
  int          pending;
  int unsigned cycles;
  logic [63:0] packets_sent;
  logic [30:0] cur_window;
  logic [15:0] cur_limit;

  tpas_item_if   item_if ();
  tpas_result_if result_if ();
  tpas_cfg_if    cfg_if ();

  tx_packet_admit_and_stamp DUT (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  tpas_admit_monitor u_admit_monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .item_mon     (item_if),
    .result_mon   (result_if),
    .cfg_mon      (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side back pressure, changed on the falling edge.
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Places one item on the channel and holds it until the transfer.
  task automatic send_item(input tpas_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid = 1'b0;
      @(negedge clk);
    end
    item_if.valid              = 1'b1;
    item_if.action             = it.action;
    item_if.count              = it.count;
    item_if.caller_stamped     = it.caller_stamped;
    item_if.end_of_burst       = it.end_of_burst;
    item_if.device_consumed_cc = it.device_consumed_cc;
    item_if.queue_level        = it.queue_level;
    item_if.device_t0          = it.device_t0;
    item_if.device_epoch       = it.device_epoch;
    item_if.device_r_shift     = it.device_r_shift;
    item_if.device_now         = it.device_now;
    do @(posedge clk); while (!item_if.ready);
    @(negedge clk);
  endtask

  // Stops sending and waits until every predicted result has come out.
  task automatic drain();
    item_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input tpas_reg_e idx, input logic [31:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [31:0] window, input logic [31:0] limit,
                               input logic [31:0] min_lead, input logic [31:0] lead);
    write_reg(REG_CC_WINDOW, window);
    write_reg(REG_QUEUE_LIMIT, limit);
    write_reg(REG_MIN_LEAD, min_lead);
    write_reg(REG_LEAD, lead);
    cfg_if.valid = 1'b0;
    cur_window   = window[30:0];
    cur_limit    = limit[15:0];
  endtask

  function automatic tpas_item_t quiet_packet();
    tpas_item_t it;
    it = '0;
    it.action = ACT_PACKET;
    return it;
  endfunction

  // Mostly well-formed packets and seeks with random device fields,
  // plus a share of fully random noise.
  function automatic tpas_item_t random_item();
    tpas_item_t it;
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(99);
    it = quiet_packet();
    it.end_of_burst   = 1'($urandom_range(1));
    it.device_t0      = $urandom;
    it.device_epoch   = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
    it.device_r_shift = 5'($urandom_range(31));
    it.device_now     = $urandom;
    it.device_consumed_cc = {$urandom, $urandom};
    it.queue_level    = 16'($urandom);
    if (roll < 65) begin
      it.count          = 64'(GRID_SAMPLES) * $urandom_range(0, 16);
      it.caller_stamped = ($urandom_range(7) == 0);
      span = (cur_window < 31'd3000) ? cur_window + 3 : 3000;
      if ($urandom_range(9) != 0) begin
        it.device_consumed_cc = packets_sent - $urandom_range(0, span);
      end
      if ($urandom_range(4) != 0) begin
        it.queue_level = 16'($urandom_range(0, cur_limit));
      end
    end else if (roll < 75) begin
      it.action = ACT_SEEK_REL;
      if ($urandom_range(9) != 0) begin
        it.count = 64'(GRID_SAMPLES) * $urandom_range(0, 64);
      end else begin
        it.count = {$urandom, $urandom} & ~64'(GRID_SAMPLES - 1);
      end
    end else if (roll < 85) begin
      it.action = ACT_SEEK_ABS;
      if ($urandom_range(1) != 0) begin
        it.count = {$urandom, $urandom} & ~64'(GRID_SAMPLES - 1);
      end else begin
        it.count = 64'(GRID_SAMPLES) * $urandom_range(0, 4096);
      end
    end else begin
      it.action         = 2'($urandom_range(3));
      it.count          = {$urandom, $urandom};
      it.caller_stamped = 1'($urandom_range(1));
    end
    return it;
  endfunction

  task automatic run_random(input int n);
    tpas_item_t it;
    repeat (n) begin
      it = random_item();
      if (it.action == ACT_PACKET) packets_sent++;
      send_item(it);
    end
    drain();
  endtask

  // Directed pass. The not-anchored refusal needs a seek before any anchor,
  // which rules out the first-packet auto seek; with one reset per run the
  // auto seek is the one covered here.
  task automatic run_directed();
    tpas_item_t it;
    load_settings(32'd5, 32'd3, 32'd0, 32'h9000_0040);
    it = quiet_packet();
    // No anchor and no seek yet: admitted without a stamp.
    send_item(it);
    // Bad element counts.
    it.count = 64'd300;
    send_item(it);
    it.count = 64'd4352;
    send_item(it);
    it.count = 64'hFFFF_FFFF_FFFF_FF00;
    send_item(it);
    it.count = '0;
    it.action = ACT_UNUSED;
    send_item(it);
    // Sequence gap beyond the window, then a negative gap.
    it.action = ACT_PACKET;
    it.device_consumed_cc = 64'hFFFF_FFFF_FFFF_FFF6;
    send_item(it);
    it.device_consumed_cc = 64'd100;
    it.caller_stamped = 1'b1;
    it.device_epoch = 8'hFF;
    send_item(it);
    // Queue at and above the limit.
    it.caller_stamped = 1'b0;
    it.device_epoch = 8'h00;
    it.queue_level = 16'd3;
    send_item(it);
    it.queue_level = 16'hFFFF;
    send_item(it);
    // First stamped packet: anchor latch and auto seek with wrapping lead.
    it.queue_level = '0;
    it.count = 64'd4096;
    it.end_of_burst = 1'b1;
    it.device_t0 = 32'hFFFF_FF00;
    it.device_epoch = 8'h5A;
    it.device_r_shift = 5'd5;
    it.device_now = 32'hF000_0000;
    send_item(it);
    it.count = 64'd256;
    it.end_of_burst = 1'b0;
    it.device_epoch = 8'h00;
    it.device_r_shift = 5'd31;
    it.device_now = $urandom;
    send_item(it);
    // Seeks: misaligned, forward, backward, and absolute with relatch.
    it.action = ACT_SEEK_REL;
    it.count = 64'd300;
    send_item(it);
    it.count = 64'd512;
    send_item(it);
    it.action = ACT_SEEK_ABS;
    it.count = '0;
    send_item(it);
    it.count = 64'h0000_0100_0000_0000;
    send_item(it);
    it.count = 64'h0000_0100_0000_1000;
    it.device_epoch = 8'h33;
    it.device_t0 = 32'h1234_5678;
    it.device_r_shift = 5'd0;
    send_item(it);
    it.action = ACT_PACKET;
    it.count = '0;
    it.end_of_burst = 1'b1;
    send_item(it);
    it.action = ACT_SEEK_ABS;
    it.count = 64'h8000_0000_0000_0000;
    it.device_epoch = 8'hC3;
    it.device_r_shift = 5'd31;
    it.device_t0 = '0;
    send_item(it);
    it.action = ACT_PACKET;
    it.count = 64'd4096;
    send_item(it);
    // Relative seek that wraps the position.
    it.action = ACT_SEEK_REL;
    it.count = 64'hFFFF_FFFF_FFFF_FF00;
    send_item(it);
    it.action = ACT_PACKET;
    it.count = 64'd512;
    it.caller_stamped = 1'b1;
    send_item(it);
    drain();
    // A zero queue limit refuses everything as full.
    load_settings(32'd2000, 32'd0, 32'h0000_0010, 32'd0);
    it = quiet_packet();
    send_item(it);
    it.device_epoch = 8'h01;
    send_item(it);
    drain();
  endtask

  // Stimulus and verdict.
  initial begin
    rst_n         = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 84;
    packets_sent  = '0;
    cur_window    = CC_WINDOW_RESET;
    cur_limit     = QUEUE_LIMIT_RESET;
    item_if.valid = 1'b0;
    item_if.action = ACT_PACKET;
    item_if.count = '0;
    item_if.caller_stamped = 1'b0;
    item_if.end_of_burst = 1'b0;
    item_if.device_consumed_cc = '0;
    item_if.queue_level = '0;
    item_if.device_t0 = '0;
    item_if.device_epoch = '0;
    item_if.device_r_shift = '0;
    item_if.device_now = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_CC_WINDOW;
    cfg_if.data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    run_directed();
    packets_sent = 64'd8;

    // Widest window and limit, with window, limit and minimum lead written with every bit set.
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    run_random(150);

    // Window and limit of one; sender mostly idle, receiver mostly ready.
    send_idle_pct = 84;
    recv_idle_pct = 18;
    load_settings(32'd1, 32'd1, 32'd0, 32'hFFFF_FFFF);
    run_random(150);

    // Random settings with a moderate window and limit, no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_settings($urandom_range(1, 300), $urandom_range(1, 40), $urandom, $urandom);
    run_random(150);

    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/tpas_pkg.sv
design/tpas_if.sv
design/tpas_cfg_regs.sv
design/tpas_core.sv
design/tx_packet_admit_and_stamp.sv
tb/tpas_admit_monitor.sv
tb/tx_packet_admit_and_stamp_tb.sv
